@@ design/mrwt_pkg.sv @@
// Package for the Miller-Rabin witness test block.
// Holds operand widths, transaction field layout, test kinds and the multiplier request type.
// No dependencies.
package mrwt_pkg;

   localparam int DATA_WIDTH  = 64;
   localparam int OPND_W      = DATA_WIDTH - 1;
   localparam int FIELD_W     = 63;
   localparam int REQ_TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = 8;
   localparam int T_W         = $clog2(OPND_W);

   localparam logic KIND_STRONG = 1'b0;
   localparam logic KIND_FERMAT = 1'b1;

   typedef logic [OPND_W-1:0] opnd_type;

   typedef struct packed {
      logic     start;
      opnd_type x;
      opnd_type y;
      opnd_type m;
   } mul_req_type;

endpackage

@@ design/miller_rabin_witness_test.sv @@
// Top level of the Miller-Rabin witness test: sequencer around one modular multiplier.
// Depends on mrwt_pkg and mrwt_modmul.
//
// One transaction in gives one transaction out. Kind 0 runs one strong probable-prime
// round of candidate n to base a; kind 1 checks a^n mod n == a. A candidate below 3 or
// a base outside 2..n-1 returns bad_operand with passes low. Otherwise the work is set
// by the single shift-and-add multiplier: each modular product steps through the bits
// of its first operand. An item needs up to two products per exponent bit plus up to
// t-1 squarings, where n-1 = u*2^t, after the t trailing zeros of n-1 are stripped.
// The block takes no new item while one is in work; a finished result may wait in the
// output register while the next item is accepted.
module miller_rabin_witness_test
   import mrwt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // candidate, base, zero pad
   input  logic                   req_tuser,  // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // passes, bad_operand, zero pad
);

   typedef enum logic [3:0] {
      IDLE, CHECK, STRIP, POW, WAIT_MUL, WAIT_SQB, FIN, WAIT_SQX, DONE
   } state_type;

   state_type       state_ff, state_in;
   opnd_type        n_ff, n_in;
   opnd_type        b_ff, b_in;
   opnd_type        a_ff, a_in;
   opnd_type        e_ff, e_in;
   opnd_type        r_ff, r_in;
   logic [T_W-1:0]  t_ff, t_in;
   logic            kind_ff, kind_in;
   logic            pass_ff, pass_in;
   logic            bad_ff, bad_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_pass_ff, rsp_pass_in;
   logic            rsp_bad_ff, rsp_bad_in;
   logic            mul_start_ff, mul_start_in;
   opnd_type        mul_x_ff, mul_x_in;
   opnd_type        mul_y_ff, mul_y_in;
   mul_req_type     mul_req;
   opnd_type        product;
   logic            mul_done;
   opnd_type        n_minus_1;
   opnd_type        one;

   assign one       = opnd_type'(1);
   assign n_minus_1 = n_ff - one;
   assign mul_req   = '{start: mul_start_ff, x: mul_x_ff, y: mul_y_ff, m: n_ff};

   mrwt_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .product (product),
      .done    (mul_done)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      b_in         = b_ff;
      a_in         = a_ff;
      e_in         = e_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      kind_in      = kind_ff;
      pass_in      = pass_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pass_in  = rsp_pass_ff;
      rsp_bad_in   = rsp_bad_ff;
      mul_start_in = 1'b0;
      mul_x_in     = mul_x_ff;
      mul_y_in     = mul_y_ff;
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               n_in     = req_tdata[OPND_W-1:0];
               a_in     = req_tdata[FIELD_W+OPND_W-1:FIELD_W];
               b_in     = req_tdata[FIELD_W+OPND_W-1:FIELD_W];
               kind_in  = req_tuser;
               state_in = CHECK;
            end
         end
         CHECK: begin
            pass_in = 1'b0;
            r_in    = one;
            t_in    = '0;
            if (n_ff < opnd_type'(3) || a_ff < opnd_type'(2) || a_ff >= n_ff) begin
               bad_in   = 1'b1;
               state_in = DONE;
            end else if (kind_ff == KIND_FERMAT) begin
               bad_in   = 1'b0;
               e_in     = n_ff;
               state_in = POW;
            end else begin
               bad_in   = 1'b0;
               e_in     = n_minus_1;
               state_in = STRIP;
            end
         end
         STRIP: begin
            if (!e_ff[0]) begin
               e_in = e_ff >> 1;
               t_in = t_ff + 1'b1;
            end else begin
               state_in = POW;
            end
         end
         POW: begin
            if (e_ff == '0) begin
               state_in = FIN;
            end else if (e_ff[0]) begin
               mul_start_in = 1'b1;
               mul_x_in     = r_ff;
               mul_y_in     = b_ff;
               state_in     = WAIT_MUL;
            end else begin
               mul_start_in = 1'b1;
               mul_x_in     = b_ff;
               mul_y_in     = b_ff;
               state_in     = WAIT_SQB;
            end
         end
         WAIT_MUL: begin
            if (mul_done) begin
               r_in = product;
               if ((e_ff >> 1) == '0) begin
                  e_in     = '0;
                  state_in = FIN;
               end else begin
                  mul_start_in = 1'b1;
                  mul_x_in     = b_ff;
                  mul_y_in     = b_ff;
                  state_in     = WAIT_SQB;
               end
            end
         end
         WAIT_SQB: begin
            if (mul_done) begin
               b_in     = product;
               e_in     = e_ff >> 1;
               state_in = POW;
            end
         end
         FIN: begin
            if (kind_ff == KIND_FERMAT) begin
               pass_in  = (r_ff == a_ff);
               state_in = DONE;
            end else if (r_ff == one || r_ff == n_minus_1) begin
               pass_in  = 1'b1;
               state_in = DONE;
            end else if (t_ff <= T_W'(1)) begin
               state_in = DONE;
            end else begin
               t_in         = t_ff - 1'b1;
               mul_start_in = 1'b1;
               mul_x_in     = r_ff;
               mul_y_in     = r_ff;
               state_in     = WAIT_SQX;
            end
         end
         WAIT_SQX: begin
            if (mul_done) begin
               r_in = product;
               if (product == n_minus_1) begin
                  pass_in  = 1'b1;
                  state_in = DONE;
               end else if (t_ff <= T_W'(1)) begin
                  state_in = DONE;
               end else begin
                  t_in         = t_ff - 1'b1;
                  mul_start_in = 1'b1;
                  mul_x_in     = product;
                  mul_y_in     = product;
               end
            end
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pass_in  = pass_ff && !bad_ff;
               rsp_bad_in   = bad_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      b_ff        <= b_in;
      a_ff        <= a_in;
      e_ff        <= e_in;
      r_ff        <= r_in;
      t_ff        <= t_in;
      kind_ff     <= kind_in;
      pass_ff     <= pass_in;
      bad_ff      <= bad_in;
      rsp_pass_ff <= rsp_pass_in;
      rsp_bad_ff  <= rsp_bad_in;
      mul_x_ff    <= mul_x_in;
      mul_y_ff    <= mul_y_in;
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_start_ff <= mul_start_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-2){1'b0}}, rsp_bad_ff, rsp_pass_ff};

endmodule

@@ design/mrwt_modmul.sv @@
// Shift-and-add modular multiplier, one bit of x per cycle.
// Operands must be below the modulus; no intermediate value exceeds twice the modulus.
// Depends on mrwt_pkg.
module mrwt_modmul
   import mrwt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output opnd_type    product,
   output logic        done
);

   opnd_type             acc_ff, acc_in;
   opnd_type             x_ff, x_in;
   opnd_type             y_ff, y_in;
   opnd_type             m_ff, m_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [OPND_W:0]      sum;
   logic [OPND_W:0]      dbl;

   always_comb begin
      sum     = {1'b0, acc_ff} + {1'b0, y_ff};
      dbl     = {y_ff, 1'b0};
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = '0;
         x_in    = req.x;
         y_in    = req.y;
         m_in    = req.m;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (x_ff[0]) begin
               if (sum >= {1'b0, m_ff}) begin
                  acc_in = opnd_type'(sum - {1'b0, m_ff});
               end else begin
                  acc_in = sum[OPND_W-1:0];
               end
            end
            x_in = x_ff >> 1;
            if (dbl >= {1'b0, m_ff}) begin
               y_in = opnd_type'(dbl - {1'b0, m_ff});
            end else begin
               y_in = dbl[OPND_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

@@ tb/tb_miller_rabin_witness_test.sv @@
// Testbench for miller_rabin_witness_test: strong-round and Fermat checks over the stream ports.
// A scoreboard class predicts each verdict and compares it against the response channel.
// Depends on mrwt_pkg and the design under test.
module tb_miller_rabin_witness_test;
   import mrwt_pkg::*;

   class witness_scoreboard;
      typedef struct packed {
         logic passes;
         logic bad_operand;
      } verdict_type;

      verdict_type expected_verdicts[$];
      int          mismatches = 0;
      int          results_seen = 0;

      function logic [63:0] mod_product(logic [63:0] x, logic [63:0] y, logic [63:0] m);
         logic [63:0] acc;
         acc = '0;
         x   = x % m;
         y   = y % m;
         while (x != 0) begin
            if (x[0]) begin
               acc = acc + y;
               if (acc >= m) acc = acc - m;
            end
            x = x >> 1;
            if (y < m - y) y = y << 1;
            else y = y - (m - y);
         end
         return acc;
      endfunction

      function logic [63:0] mod_power(logic [63:0] b, logic [63:0] e, logic [63:0] m);
         logic [63:0] r;
         r = 64'd1 % m;
         b = b % m;
         while (e != 0) begin
            if (e[0]) r = mod_product(r, b, m);
            b = mod_product(b, b, m);
            e = e >> 1;
         end
         return r;
      endfunction

      function bit strong_round_passes(logic [63:0] n, logic [63:0] a);
         logic [63:0] u;
         logic [63:0] x;
         int          t;
         u = n - 1;
         t = 0;
         while (u != 0 && !u[0]) begin
            t++;
            u = u >> 1;
         end
         x = mod_power(a, u, n);
         if (x == 1 || x == n - 1) return 1'b1;
         for (int j = 1; j < t; j++) begin
            x = mod_product(x, x, n);
            if (x == n - 1) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(logic kind, opnd_type candidate, opnd_type base);
         logic [63:0] n;
         logic [63:0] a;
         verdict_type v;
         n = {1'b0, candidate};
         a = {1'b0, base};
         v = '0;
         if (n < 3 || a < 2 || a > n - 1) v.bad_operand = 1'b1;
         else if (kind == KIND_STRONG) v.passes = strong_round_passes(n, a);
         else v.passes = (mod_power(a, n, n) == a);
         expected_verdicts.push_back(v);
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] tdata);
         verdict_type exp_v;
         results_seen++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: unexpected transaction, tdata=%h", results_seen, tdata);
            return;
         end
         exp_v = expected_verdicts.pop_front();
         if (tdata[0] !== exp_v.passes || tdata[1] !== exp_v.bad_operand) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result %0d: expected passes=%0b bad_operand=%0b, ",
                         "got passes=%0b bad_operand=%0b"},
                        results_seen, exp_v.passes, exp_v.bad_operand, tdata[0], tdata[1]);
         end
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // candidate, base, zero pad
   logic                   req_tuser = 1'b0; // kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // passes, bad_operand, zero pad

   witness_scoreboard sb = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rsp_hold_left = 0;

   miller_rabin_witness_test DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // response side back-pressure; long holds are counted here
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_item(input logic kind, input opnd_type candidate, input opnd_type base);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W - 2 * FIELD_W){1'b0}}, base, candidate};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, candidate, base);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic random_item();
      logic [63:0] r1;
      logic [63:0] r2;
      logic [63:0] n64;
      logic [63:0] a64;
      int          len;
      int          pick;
      logic        kind;
      r1   = {$urandom, $urandom};
      r2   = {$urandom, $urandom};
      pick = $urandom_range(99);
      kind = 1'($urandom_range(1));
      len  = ($urandom_range(99) < 10) ? 63 : $urandom_range(20, 2);
      n64  = r1 & ((64'd1 << len) - 1);
      n64[len-1] = 1'b1;
      n64[0]     = 1'b1;
      a64  = 64'd2 + r2 % (n64 - 2);
      if (pick >= 75 && pick < 87) begin
         // raw noise across the full field width
         n64 = {1'b0, r1[62:0]};
         a64 = {1'b0, r2[62:0]};
      end else if (pick >= 87) begin
         case (pick % 4)
            0: a64 = n64 - 1;
            1: a64 = 64'd1;
            2: a64 = n64;
            default: begin
               n64[0] = 1'b0;
               if (n64 > 3) a64 = 64'd2 + r2 % (n64 - 2);
            end
         endcase
      end
      send_item(kind, n64[62:0], a64[62:0]);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 10;
      rx_idle_pct = 73;
      send_item(KIND_STRONG, 63'd3, 63'd2);
      send_item(KIND_FERMAT, 63'd3, 63'd2);
      send_item(KIND_STRONG, 63'd0, 63'd0);
      send_item(KIND_FERMAT, 63'd2, 63'd1);
      send_item(KIND_STRONG, 63'd1, 63'd2);
      send_item(KIND_STRONG, 63'd97, 63'd1);
      send_item(KIND_FERMAT, 63'd97, 63'd97);
      send_item(KIND_STRONG, 63'd97, 63'd96);
      send_item(KIND_STRONG, 63'd97, 63'h7FFF_FFFF_FFFF_FFFF);
      send_item(KIND_STRONG, 63'd10, 63'd3);
      send_item(KIND_FERMAT, 63'd10, 63'd5);
      send_item(KIND_STRONG, 63'd2047, 63'd2);
      send_item(KIND_STRONG, 63'd561, 63'd2);
      send_item(KIND_FERMAT, 63'd561, 63'd2);
      send_item(KIND_STRONG, 63'd2305843009213693951, 63'd2);
      send_item(KIND_FERMAT, 63'd2305843009213693951, 63'd1234567890123456789);
      send_item(KIND_STRONG, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFE);
      send_item(KIND_FERMAT, 63'h7FFF_FFFF_FFFF_FFFF, 63'd3);
      send_item(KIND_STRONG, 63'd9223372036854775783, 63'd9223372036854775782);
      send_item(KIND_STRONG, 63'd9223372036854775783, 63'h5555_5555_5555_5555);
      send_item(KIND_STRONG, 63'd4611686018427387905, 63'd3);
      send_item(KIND_FERMAT, 63'd4611686018427387905, 63'h2AAA_AAAA_AAAA_AAAA);
      repeat (25) random_item();
      drain_results();
      @(negedge clock);

      tx_idle_pct = 73;
      rx_idle_pct = 10;
      repeat (25) random_item();
      drain_results();
      @(negedge clock);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      @(posedge clock);
      rsp_hold_left = 2000;
      @(negedge clock);
      send_item(KIND_STRONG, 63'd2047, 63'd2);
      send_item(KIND_FERMAT, 63'd561, 63'd5);
      send_item(KIND_STRONG, 63'd97, 63'd5);
      send_item(KIND_FERMAT, 63'd91, 63'd3);
      repeat (24) random_item();
      drain_results();

      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ miller_rabin_witness_test.f @@
design/mrwt_pkg.sv
design/mrwt_modmul.sv
design/miller_rabin_witness_test.sv
tb/tb_miller_rabin_witness_test.sv
